/* design/rectangle_difference_macros.svh */
// assertion macros for the rectangle difference block
// no dependencies; included by modules that carry assertions
`ifndef RECTANGLE_DIFFERENCE_MACROS_SVH
`define RECTANGLE_DIFFERENCE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define RDIFF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdiff implication check failed");
// next-cycle implication, disabled in reset
`define RDIFF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdiff next-cycle check failed");
`else
`define RDIFF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RDIFF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/rdiff_pkg.sv */
// shared types and widths for the rectangle difference block
// no dependencies
`default_nettype none
package rdiff_pkg;

    localparam int COORD_BITS = 15;
    localparam int POS_BITS   = COORD_BITS + 1;
    localparam int CALC_BITS  = COORD_BITS + 2;
    localparam int NUM_PIECES = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [POS_BITS-1:0]   pos_t;
    typedef logic        [COORD_BITS-1:0] size_t;
    typedef logic signed [CALC_BITS-1:0]  calc_t;

    typedef struct packed {
        pos_t  x;
        pos_t  y;
        size_t w;
        size_t h;
    } piece_t;

    // up to four pieces; bit order of mask gives emission order
    typedef struct packed {
        piece_t [NUM_PIECES-1:0] p;
        logic   [NUM_PIECES-1:0] mask;
    } piece_set_t;

endpackage
`default_nettype wire

/* design/rdiff_clip.sv */
// combinational normalise, intersect and split of rectangle a by rectangle b
// depends on rdiff_pkg
`default_nettype none
module rdiff_clip
(
    input  wire rdiff_pkg::coord_t     a_x,
    input  wire rdiff_pkg::coord_t     a_y,
    input  wire rdiff_pkg::coord_t     a_w,
    input  wire rdiff_pkg::coord_t     a_h,
    input  wire rdiff_pkg::coord_t     b_x,
    input  wire rdiff_pkg::coord_t     b_y,
    input  wire rdiff_pkg::coord_t     b_w,
    input  wire rdiff_pkg::coord_t     b_h,
    output rdiff_pkg::piece_set_t      set
);
    import rdiff_pkg::*;

    calc_t ax, ay, aw, ah, bx, by, bw, bh;
    calc_t ar, ab, br, bb;
    calc_t cx, cy, cr, cb, cw, ch;
    logic  overlap;

    function automatic piece_t make_piece(calc_t x, calc_t y, calc_t w, calc_t h);
        piece_t pc;
        pc.x = pos_t'(x[POS_BITS-1:0]);
        pc.y = pos_t'(y[POS_BITS-1:0]);
        pc.w = w[COORD_BITS-1:0];
        pc.h = h[COORD_BITS-1:0];
        return pc;
    endfunction

    always_comb
    begin
        // negative size: flip it and pull the corner back
        aw = (a_w < 0) ? -calc_t'(a_w) : calc_t'(a_w);
        ax = (a_w < 0) ? calc_t'(a_x) + calc_t'(a_w) : calc_t'(a_x);
        ah = (a_h < 0) ? -calc_t'(a_h) : calc_t'(a_h);
        ay = (a_h < 0) ? calc_t'(a_y) + calc_t'(a_h) : calc_t'(a_y);
        bw = (b_w < 0) ? -calc_t'(b_w) : calc_t'(b_w);
        bx = (b_w < 0) ? calc_t'(b_x) + calc_t'(b_w) : calc_t'(b_x);
        bh = (b_h < 0) ? -calc_t'(b_h) : calc_t'(b_h);
        by = (b_h < 0) ? calc_t'(b_y) + calc_t'(b_h) : calc_t'(b_y);

        ar = ax + aw;
        ab = ay + ah;
        br = bx + bw;
        bb = by + bh;

        cx = (ax > bx) ? ax : bx;
        cy = (ay > by) ? ay : by;
        cr = (ar < br) ? ar : br;
        cb = (ab < bb) ? ab : bb;
        cw = cr - cx;
        ch = cb - cy;
        overlap = (cw > 0) && (ch > 0);

        set.p[0] = make_piece(ax, ay, aw, cy - ay);
        set.p[1] = make_piece(ax, cb, aw, ab - cb);
        set.p[2] = make_piece(ax, cy, cx - ax, ch);
        set.p[3] = make_piece(cr, cy, ar - cr, ch);
        set.mask = {(ar != cr), (ax != cx), (ab != cb), (ay != cy)};

        if (!overlap)
        begin
            set.p[0] = make_piece(ax, ay, aw, ah);
            set.mask = 4'b0001;
        end
    end

endmodule
`default_nettype wire

/* design/rdiff_emit.sv */
// piece bank and output register; sends pending pieces one per cycle unless the output stalls
// depends on rdiff_pkg and rectangle_difference_macros.svh
`default_nettype none
`include "rectangle_difference_macros.svh"
module rdiff_emit
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        set_valid,
    input  wire rdiff_pkg::piece_set_t set,
    output logic                       set_ready,
    output logic                       out_valid,
    input  wire                        out_stall,
    output rdiff_pkg::pos_t            piece_x,
    output rdiff_pkg::pos_t            piece_y,
    output rdiff_pkg::size_t           piece_w,
    output rdiff_pkg::size_t           piece_h,
    output logic                       last_piece
);
    import rdiff_pkg::*;

    logic [NUM_PIECES-1:0]   mask_reg, mask_next;
    piece_t [NUM_PIECES-1:0] bank_reg;
    logic                    out_valid_reg, out_valid_next;
    piece_t                  out_piece_reg;
    logic                    last_reg;

    logic [NUM_PIECES-1:0]   sel, rest, mask_after;
    piece_t                  pick;
    logic                    take, load_set;

    always_comb
    begin
        sel  = mask_reg & (~mask_reg + NUM_PIECES'(1));
        rest = mask_reg & ~sel;
        pick = '0;
        for (int i = 0; i < NUM_PIECES; i++)
        begin
            if (sel[i])
            begin
                pick = bank_reg[i];
            end
        end
        take       = (mask_reg != '0) && (!out_valid_reg || !out_stall);
        mask_after = take ? rest : mask_reg;
        set_ready  = (mask_after == '0);
        load_set   = set_valid && set_ready;
        mask_next  = load_set ? set.mask : mask_after;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_set)
        begin
            bank_reg <= set.p;
        end
        if (take)
        begin
            out_piece_reg <= pick;
            last_reg      <= (rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign piece_x    = out_piece_reg.x;
    assign piece_y    = out_piece_reg.y;
    assign piece_w    = out_piece_reg.w;
    assign piece_h    = out_piece_reg.h;
    assign last_piece = last_reg;

    // a non-final word on the port means its siblings are still banked
    `RDIFF_ASSERT_IMP(a_more_banked, clk, rst_n, out_valid_reg && !last_reg, mask_reg != '0)
    // banked pieces are never dropped or overwritten without a transfer
    `RDIFF_ASSERT_NXT(a_bank_holds, clk, rst_n, (mask_reg != '0) && !take, $stable(mask_reg))
    // the output word only appears by moving a banked piece
    `RDIFF_ASSERT_IMP(a_out_from_bank, clk, rst_n, $rose(out_valid_reg), $past(mask_reg != '0))

endmodule
`default_nettype wire

/* design/rectangle_difference.sv */
// top level of the rectangle difference block
// depends on rdiff_pkg, rdiff_clip and rdiff_emit
`default_nettype none
// Rectangle difference: each input word carries rectangles a and b as corner plus
// signed size. Both are normalised (a negative size is negated and the corner moved
// back by it), then the parts of a lying outside b are sent as output words in the
// order top band, bottom band, left strip, right strip, skipping empty parts; the
// final word of an item has last_piece set. If a and b do not overlap with positive
// area, a alone is sent; if b covers a, nothing is sent. An item passes an input
// register, is split combinationally into a bank of up to four pieces, and the bank
// drains one piece a cycle through the output register unless the output is stalled.
// The output port sets the pace, and the input register can hold the next item while
// the bank still drains. No reset sweep.
module rectangle_difference
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire rdiff_pkg::coord_t  a_x,
    input  wire rdiff_pkg::coord_t  a_y,
    input  wire rdiff_pkg::coord_t  a_w,
    input  wire rdiff_pkg::coord_t  a_h,
    input  wire rdiff_pkg::coord_t  b_x,
    input  wire rdiff_pkg::coord_t  b_y,
    input  wire rdiff_pkg::coord_t  b_w,
    input  wire rdiff_pkg::coord_t  b_h,
    output logic                    out_valid,
    input  wire                     out_stall,
    output rdiff_pkg::pos_t         piece_x,
    output rdiff_pkg::pos_t         piece_y,
    output rdiff_pkg::size_t        piece_w,
    output rdiff_pkg::size_t        piece_h,
    output logic                    last_piece
);
    import rdiff_pkg::*;

    // input register, one word deep
    logic   in_valid_reg, in_valid_next;
    coord_t ax_reg, ay_reg, aw_reg, ah_reg;
    coord_t bx_reg, by_reg, bw_reg, bh_reg;
    logic   in_ready;

    // split result and bank handshake
    piece_set_t set;
    logic       set_ready;

    // register is free when empty or when its word moves into the bank
    assign in_ready = !in_valid_reg || set_ready;
    assign in_stall = !in_ready;

    always_comb
    begin
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ax_reg <= a_x;
            ay_reg <= a_y;
            aw_reg <= a_w;
            ah_reg <= a_h;
            bx_reg <= b_x;
            by_reg <= b_y;
            bw_reg <= b_w;
            bh_reg <= b_h;
        end
    end

    // normalise, intersect and split into up to four pieces
    rdiff_clip u_clip
    (
        .a_x (ax_reg),
        .a_y (ay_reg),
        .a_w (aw_reg),
        .a_h (ah_reg),
        .b_x (bx_reg),
        .b_y (by_reg),
        .b_w (bw_reg),
        .b_h (bh_reg),
        .set (set)
    );

    // bank the pieces and send them one word a cycle unless the output stalls
    rdiff_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_valid  (in_valid_reg),
        .set        (set),
        .set_ready  (set_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .piece_x    (piece_x),
        .piece_y    (piece_y),
        .piece_w    (piece_w),
        .piece_h    (piece_h),
        .last_piece (last_piece)
    );

endmodule
`default_nettype wire
